/* rtl/assert_macros.svh */
// Assertion macros shared by the RTSP response parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define RRHP_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A same-cycle implication checked at every rising clock edge outside reset.
`define RRHP_ASSERT_IMPL(lbl, ante, cons, msg) \
  `RRHP_ASSERT_PROP(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/rrhp_pkg.sv */
// Types, constants and character tables for the RTSP response parser.
package rrhp_pkg;

  localparam int BUFFER_BYTES    = 2048;
  localparam int STATUS_LINE_MAX = 256;
  localparam int CNT_MAX = (BUFFER_BYTES > STATUS_LINE_MAX) ? BUFFER_BYTES : STATUS_LINE_MAX;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  localparam int PROTO_LEN        = 9;
  localparam int PROTO_VER_POS    = 5;
  localparam int NAME_LEN         = 14;
  localparam int NAME_FOLD_POS_A  = 0;
  localparam int NAME_FOLD_POS_B  = 8;
  localparam int STATUS_DIGIT_END = 12;
  localparam int LEN_COLON_POS    = 15;
  localparam int LEN_DIGIT_START  = 16;
  localparam int LEN_LINE_MIN     = 19;
  localparam int BLANK_LINE_LEN   = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_STATUS = 3'd1,
    PH_HEADER = 3'd2,
    PH_BODY   = 3'd3,
    PH_DONE   = 3'd4,
    PH_FAILED = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_PROTOCOL  = 3'd1,
    ERR_ZERO      = 3'd2,
    ERR_LINE_LONG = 3'd3,
    ERR_OVERFLOW  = 3'd4,
    ERR_NO_LENGTH = 3'd5,
    ERR_TOO_LARGE = 3'd6,
    ERR_CLOSED    = 3'd7
  } err_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [7:0]            data;
    logic                  is_digit;
    logic [3:0]            digit;
    logic                  is_lf;
    logic                  is_cr;
    logic                  is_colon;
    logic [PROTO_LEN-1:0]  proto_hit;
    logic [NAME_LEN-1:0]   name_hit;
  } item_t;

  function automatic logic [7:0] proto_char(input logic [3:0] k);
    logic [7:0] c;
    unique case (k)
      4'd0:    c = 8'h52;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h53;
      4'd3:    c = 8'h50;
      4'd4:    c = 8'h2F;
      4'd5:    c = 8'h31;
      4'd6:    c = 8'h2E;
      4'd7:    c = 8'h30;
      4'd8:    c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] name_char(input logic [3:0] k);
    logic [7:0] c;
    unique case (k)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h4C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/rrhp_front.sv */
// Input handshake and byte classification ahead of the item queue.
module rrhp_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_cmd,
  input  logic [7:0]          in_rx_byte,
  input  logic                q_full,
  output logic                push,
  output rrhp_pkg::item_t     item
);

  always_comb begin
    in_stall = q_full;
    push     = in_valid && !q_full;

    item.cmd      = rrhp_pkg::cmd_t'(in_cmd);
    item.data     = in_rx_byte;
    item.is_digit = (in_rx_byte >= rrhp_pkg::CH_ZERO) && (in_rx_byte <= rrhp_pkg::CH_NINE);
    item.digit    = 4'(in_rx_byte - rrhp_pkg::CH_ZERO);
    item.is_lf    = (in_rx_byte == rrhp_pkg::CH_LF);
    item.is_cr    = (in_rx_byte == rrhp_pkg::CH_CR);
    item.is_colon = (in_rx_byte == rrhp_pkg::CH_COLON);

    for (int k = 0; k < rrhp_pkg::PROTO_LEN; k++) begin
      if (k == rrhp_pkg::PROTO_VER_POS) begin
        item.proto_hit[k] = (in_rx_byte == rrhp_pkg::CH_ONE) ||
                            (in_rx_byte == rrhp_pkg::CH_TWO);
      end else begin
        item.proto_hit[k] = (in_rx_byte == rrhp_pkg::proto_char(4'(k)));
      end
    end

    for (int k = 0; k < rrhp_pkg::NAME_LEN; k++) begin
      if (k == rrhp_pkg::NAME_FOLD_POS_A || k == rrhp_pkg::NAME_FOLD_POS_B) begin
        item.name_hit[k] = (in_rx_byte == rrhp_pkg::name_char(4'(k))) ||
                           (in_rx_byte == rrhp_pkg::name_char(4'(k)) + rrhp_pkg::CASE_GAP);
      end else begin
        item.name_hit[k] = (in_rx_byte == rrhp_pkg::name_char(4'(k)));
      end
    end
  end

endmodule

/* rtl/rrhp_fifo.sv */
// Short queue of classified items between the front and the parser.
`include "assert_macros.svh"

module rrhp_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rrhp_pkg::item_t  wr_item,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output rrhp_pkg::item_t  rd_item
);

  rrhp_pkg::item_t                mem_r [rrhp_pkg::QUEUE_DEPTH];
  logic [rrhp_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [rrhp_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [rrhp_pkg::QCNT_W-1:0]    count_r, count_nxt;

  always_comb begin
    full     = (count_r == rrhp_pkg::QCNT_W'(rrhp_pkg::QUEUE_DEPTH));
    rd_valid = (count_r != '0);
    rd_item  = mem_r[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == rrhp_pkg::QPTR_W'(rrhp_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == rrhp_pkg::QPTR_W'(rrhp_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  `RRHP_ASSERT_PROP(a_fill_tracks_push, (push && !pop) |=> (count_r == $past(count_r) + 1'b1), "queue fill count did not grow on a lone push")

endmodule

/* rtl/rrhp_back.sv */
// Response parser state machine with the registered result stage.
`include "assert_macros.svh"

module rrhp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  rrhp_pkg::item_t        it,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_phase,
  output logic [2:0]             out_error_kind,
  output logic [9:0]             out_status_number,
  output logic [15:0]            out_body_length,
  output logic                   out_body_valid,
  output logic [7:0]             out_body_byte,
  output logic                   out_body_last
);

  localparam int CW = rrhp_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_STATUS = 6'b000010,
    S_HEADER = 6'b000100,
    S_BODY   = 6'b001000,
    S_DONE   = 6'b010000,
    S_FAILED = 6'b100000
  } state_t;

  state_t            st_r, st_nxt;
  rrhp_pkg::err_t    err_r, err_nxt;
  logic [CW-1:0]     total_r, total_nxt;
  logic [CW-1:0]     line_r, line_nxt;
  logic [CW-1:0]     colon_r, colon_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [9:0]        status_r, status_nxt;
  logic              prefix_ok_r, prefix_ok_nxt;
  logic              name_ok_r, name_ok_nxt;
  logic              digits_done_r, digits_done_nxt;
  logic              starts_cr_r, starts_cr_nxt;
  logic              last_digit_r, last_digit_nxt;
  logic [15:0]       len_r, len_nxt;
  logic [15:0]       acc_r, acc_nxt;
  logic [15:0]       acc_prev_r, acc_prev_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_phase_r;
  logic [2:0]        out_err_r;
  logic [9:0]        out_status_r;
  logic [15:0]       out_len_r;
  logic              out_bv_r, out_bl_r;
  logic [7:0]        out_byte_r;

  logic              busy;
  logic              fail_en;
  rrhp_pkg::err_t    fail_code;
  logic              clear_line;
  logic              hdr_end;
  logic              bv, bl;
  logic [CW-1:0]     tot_inc;
  logic [CW-1:0]     line_inc;
  logic [13:0]       status_mul;
  logic [19:0]       acc_mul;
  logic [16:0]       need_bytes;
  logic [2:0]        phase_code;

  always_comb begin
    st_nxt          = st_r;
    err_nxt         = err_r;
    total_nxt       = total_r;
    line_nxt        = line_r;
    colon_nxt       = colon_r;
    rem_nxt         = rem_r;
    status_nxt      = status_r;
    prefix_ok_nxt   = prefix_ok_r;
    name_ok_nxt     = name_ok_r;
    digits_done_nxt = digits_done_r;
    starts_cr_nxt   = starts_cr_r;
    last_digit_nxt  = last_digit_r;
    len_nxt         = len_r;
    acc_nxt         = acc_r;
    acc_prev_nxt    = acc_prev_r;
    fail_en         = 1'b0;
    fail_code       = rrhp_pkg::ERR_NONE;
    clear_line      = 1'b0;
    hdr_end         = 1'b0;
    bv              = 1'b0;
    bl              = 1'b0;

    pop        = q_valid && (!out_valid_r || !out_stall);
    busy       = (st_r == S_STATUS) || (st_r == S_HEADER) || (st_r == S_BODY);
    tot_inc    = total_r + 1'b1;
    line_inc   = line_r + 1'b1;
    status_mul = ({4'b0, status_r} << 3) + ({4'b0, status_r} << 1) + 14'(it.digit);
    acc_mul    = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + 20'(it.digit);
    need_bytes = {1'b0, len_r} + 17'(tot_inc);

    if (pop) begin
      unique case (it.cmd)
        rrhp_pkg::CMD_BEGIN: begin
          st_nxt        = S_STATUS;
          err_nxt       = rrhp_pkg::ERR_NONE;
          total_nxt     = '0;
          status_nxt    = '0;
          prefix_ok_nxt = 1'b1;
          len_nxt       = '0;
          rem_nxt       = '0;
          clear_line    = 1'b1;
        end
        rrhp_pkg::CMD_CLOSE: begin
          if (busy) begin
            fail_en   = 1'b1;
            fail_code = rrhp_pkg::ERR_CLOSED;
          end
        end
        rrhp_pkg::CMD_BYTE: begin
          unique case (st_r)
            S_STATUS: begin
              total_nxt = tot_inc;
              if (total_r < CW'(rrhp_pkg::PROTO_LEN)) begin
                if (!it.proto_hit[total_r[3:0]]) begin
                  prefix_ok_nxt = 1'b0;
                end
              end else if (total_r < CW'(rrhp_pkg::STATUS_DIGIT_END) && !digits_done_r) begin
                if (it.is_digit) begin
                  status_nxt = status_mul[9:0];
                end else begin
                  digits_done_nxt = 1'b1;
                end
              end
              if (it.is_lf) begin
                if (!prefix_ok_nxt) begin
                  fail_en   = 1'b1;
                  fail_code = rrhp_pkg::ERR_PROTOCOL;
                end else if (status_nxt == '0) begin
                  fail_en   = 1'b1;
                  fail_code = rrhp_pkg::ERR_ZERO;
                end else if (tot_inc >= CW'(rrhp_pkg::STATUS_LINE_MAX)) begin
                  fail_en   = 1'b1;
                  fail_code = rrhp_pkg::ERR_LINE_LONG;
                end else begin
                  clear_line = 1'b1;
                  if (tot_inc >= CW'(rrhp_pkg::BUFFER_BYTES)) begin
                    fail_en   = 1'b1;
                    fail_code = rrhp_pkg::ERR_NO_LENGTH;
                  end else begin
                    st_nxt = S_HEADER;
                  end
                end
              end else if (tot_inc >= CW'(rrhp_pkg::STATUS_LINE_MAX)) begin
                fail_en   = 1'b1;
                fail_code = rrhp_pkg::ERR_LINE_LONG;
              end
            end
            S_HEADER: begin
              total_nxt = tot_inc;
              line_nxt  = line_inc;
              if (it.is_lf) begin
                if (line_inc == CW'(rrhp_pkg::BLANK_LINE_LEN) && starts_cr_r) begin
                  hdr_end = 1'b1;
                  if (len_r == '0) begin
                    fail_en   = 1'b1;
                    fail_code = rrhp_pkg::ERR_NO_LENGTH;
                  end else if (need_bytes > 17'(rrhp_pkg::BUFFER_BYTES)) begin
                    fail_en   = 1'b1;
                    fail_code = rrhp_pkg::ERR_TOO_LARGE;
                  end else begin
                    rem_nxt = len_r[CW-1:0];
                    st_nxt  = S_BODY;
                  end
                end else begin
                  if (colon_r == CW'(rrhp_pkg::LEN_COLON_POS) && name_ok_r &&
                      line_inc >= CW'(rrhp_pkg::LEN_LINE_MIN)) begin
                    len_nxt = last_digit_r ? acc_prev_r : acc_r;
                  end
                  clear_line = 1'b1;
                end
              end else begin
                if (line_r == '0) begin
                  starts_cr_nxt = it.is_cr;
                end
                if (colon_r == '0 && it.is_colon) begin
                  colon_nxt = line_inc;
                end
                if (line_r < CW'(rrhp_pkg::NAME_LEN)) begin
                  if (!it.name_hit[line_r[3:0]]) begin
                    name_ok_nxt = 1'b0;
                  end
                end
                if (line_r >= CW'(rrhp_pkg::LEN_DIGIT_START)) begin
                  if (!digits_done_r && it.is_digit) begin
                    acc_prev_nxt   = acc_r;
                    acc_nxt        = (acc_mul > 20'hFFFF) ? 16'hFFFF : acc_mul[15:0];
                    last_digit_nxt = 1'b1;
                  end else begin
                    digits_done_nxt = 1'b1;
                    last_digit_nxt  = 1'b0;
                  end
                end
              end
              if (!hdr_end && tot_inc >= CW'(rrhp_pkg::BUFFER_BYTES)) begin
                fail_en   = 1'b1;
                fail_code = rrhp_pkg::ERR_OVERFLOW;
              end
            end
            S_BODY: begin
              total_nxt = tot_inc;
              bv        = 1'b1;
              rem_nxt   = (rem_r != '0) ? rem_r - 1'b1 : rem_r;
              if (rem_nxt == '0) begin
                bl     = 1'b1;
                st_nxt = S_DONE;
              end
            end
            default: begin
            end
          endcase
        end
        rrhp_pkg::CMD_NONE: begin
        end
        default: begin
        end
      endcase
    end

    if (clear_line) begin
      line_nxt        = '0;
      colon_nxt       = '0;
      name_ok_nxt     = 1'b1;
      digits_done_nxt = 1'b0;
      starts_cr_nxt   = 1'b0;
      acc_nxt         = '0;
      acc_prev_nxt    = '0;
      last_digit_nxt  = 1'b0;
    end

    if (fail_en) begin
      st_nxt  = S_FAILED;
      err_nxt = fail_code;
      len_nxt = '0;
    end

    unique case (st_nxt)
      S_IDLE:   phase_code = rrhp_pkg::PH_IDLE;
      S_STATUS: phase_code = rrhp_pkg::PH_STATUS;
      S_HEADER: phase_code = rrhp_pkg::PH_HEADER;
      S_BODY:   phase_code = rrhp_pkg::PH_BODY;
      S_DONE:   phase_code = rrhp_pkg::PH_DONE;
      S_FAILED: phase_code = rrhp_pkg::PH_FAILED;
      default:  phase_code = rrhp_pkg::PH_IDLE;
    endcase

    out_valid_nxt = pop || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_IDLE;
      err_r         <= rrhp_pkg::ERR_NONE;
      total_r       <= '0;
      line_r        <= '0;
      colon_r       <= '0;
      rem_r         <= '0;
      status_r      <= '0;
      prefix_ok_r   <= 1'b1;
      name_ok_r     <= 1'b1;
      digits_done_r <= 1'b0;
      starts_cr_r   <= 1'b0;
      last_digit_r  <= 1'b0;
      len_r         <= '0;
      acc_r         <= '0;
      acc_prev_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      err_r         <= err_nxt;
      total_r       <= total_nxt;
      line_r        <= line_nxt;
      colon_r       <= colon_nxt;
      rem_r         <= rem_nxt;
      status_r      <= status_nxt;
      prefix_ok_r   <= prefix_ok_nxt;
      name_ok_r     <= name_ok_nxt;
      digits_done_r <= digits_done_nxt;
      starts_cr_r   <= starts_cr_nxt;
      last_digit_r  <= last_digit_nxt;
      len_r         <= len_nxt;
      acc_r         <= acc_nxt;
      acc_prev_r    <= acc_prev_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_phase_r  <= phase_code;
      out_err_r    <= err_nxt;
      out_status_r <= status_nxt;
      out_len_r    <= len_nxt;
      out_bv_r     <= bv;
      out_bl_r     <= bl;
      out_byte_r   <= bv ? it.data : 8'h00;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_phase         = out_phase_r;
  assign out_error_kind    = out_err_r;
  assign out_status_number = out_status_r;
  assign out_body_length   = out_len_r;
  assign out_body_valid    = out_bv_r;
  assign out_body_byte     = out_byte_r;
  assign out_body_last     = out_bl_r;

  `RRHP_ASSERT_IMPL(a_last_has_byte, out_valid_r && out_bl_r, out_bv_r, "last flag without a body byte")
  `RRHP_ASSERT_IMPL(a_byte_in_body, out_valid_r && out_bv_r, (out_phase_r == rrhp_pkg::PH_BODY) || (out_phase_r == rrhp_pkg::PH_DONE), "body byte outside the body phase")
  `RRHP_ASSERT_IMPL(a_error_iff_failed, out_valid_r, (out_err_r != rrhp_pkg::ERR_NONE) == (out_phase_r == rrhp_pkg::PH_FAILED), "error kind disagrees with the failed phase")

endmodule

/* rtl/rtsp_response_header_parser.sv */
// Top level of the RTSP response status and header parser.
//
// Each input item carries a command (begin a new response, received byte,
// partner closed, or none) and a byte. Every accepted item produces exactly one
// result item with the current phase, error kind, status code, parsed
// Content-Length, and, in the body phase, the content byte with its flags.
// The front classifies each byte and writes it into a two-entry queue; the
// parser takes one item per cycle from the queue into its output register
// whenever that register is empty or the receiver takes its result. Each
// item is held in a queue entry and then in the output register before its
// result can be taken; throughput is one item per cycle while not stalled.
// When the receiver stalls, the result holds and the queue fills; in_stall
// rises once both queue entries are occupied, and nothing is dropped.
// After reset the parser is idle, bytes and closes are ignored until a
// begin command, and no result is pending.
module rtsp_response_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_phase,
  output logic [2:0]  out_error_kind,
  output logic [9:0]  out_status_number,
  output logic [15:0] out_body_length,
  output logic        out_body_valid,
  output logic [7:0]  out_body_byte,
  output logic        out_body_last
);

  rrhp_pkg::item_t front_item;
  rrhp_pkg::item_t queue_item;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_valid;

  rrhp_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .item       (front_item)
  );

  rrhp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_item  (front_item),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_item  (queue_item)
  );

  rrhp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .it                (queue_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_phase         (out_phase),
    .out_error_kind    (out_error_kind),
    .out_status_number (out_status_number),
    .out_body_length   (out_body_length),
    .out_body_valid    (out_body_valid),
    .out_body_byte     (out_body_byte),
    .out_body_last     (out_body_last)
  );

endmodule
